// ===== rtl/core/mlr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the midpoint line rasterizer.
// No dependencies; every other file refers to this package by scoped names.
package mlr_pkg;

   // Coordinate width, one extra bit for compares, and decision width
   localparam int COORD_BITS = 12;
   localparam int EXT_BITS   = COORD_BITS + 1;
   localparam int DEC_BITS   = COORD_BITS + 4;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [EXT_BITS-1:0]   ext_coord_type;
   typedef logic        [COORD_BITS-1:0] delta_type;
   typedef logic signed [DEC_BITS-1:0]   decision_type;

   // Command codes carried by an input item
   typedef enum logic [1:0] {
      FUNC_MOVE = 2'd0,
      FUNC_LINE = 2'd1,
      FUNC_STEP = 2'd2
   } func_type;

   // Octant class of the latched line
   typedef enum logic [2:0] {
      CASE_VERT  = 3'd0,
      CASE_SH_UP = 3'd1,
      CASE_SH_DN = 3'd2,
      CASE_ST_UP = 3'd3,
      CASE_ST_DN = 3'd4
   } line_case_type;

   typedef struct packed {
      func_type  func;
      coord_type point_x;
      coord_type point_y;
   } req_item_type;

   typedef struct packed {
      coord_type pixel_x;
      coord_type pixel_y;
      logic      last;
   } rsp_item_type;

   // Walk state of the current line
   typedef struct packed {
      line_case_type line_case;
      coord_type     walk_x;
      coord_type     walk_y;
      coord_type     stop_coord;
      delta_type     delta_x;
      delta_type     delta_y;
      decision_type  decision;
   } line_state_type;

   // Sign-extend a coordinate by one bit
   function automatic ext_coord_type sext(coord_type v);
      return {v[COORD_BITS-1], v};
   endfunction

   // Zero-extend a magnitude to decision width
   function automatic decision_type widen(delta_type v);
      return {{(DEC_BITS-COORD_BITS){1'b0}}, v};
   endfunction

endpackage

// ===== rtl/core/midpoint_line_rasterizer.sv =====
`timescale 1ns / 1ps
// A step item is held in the input register, then its pixel is written to the result register.
// Throughput: one item per cycle while the result register is not stalled; one pass of setup
// or step logic between the input register and the result register sets that figure.
// Reset (synchronous, active high): pen at the origin, no line active, both
// registers empty. Depends on mlr_pkg, mlr_line_setup, mlr_pixel_step.
module midpoint_line_rasterizer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  mlr_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output mlr_pkg::rsp_item_type rsp_item
);

   logic                    in_valid_ff, in_valid_in;
   mlr_pkg::req_item_type   in_item_ff;
   mlr_pkg::coord_type      pen_x_ff, pen_x_in;
   mlr_pkg::coord_type      pen_y_ff, pen_y_in;
   logic                    busy_ff, busy_in;
   mlr_pkg::line_state_type line_ff, line_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   mlr_pkg::rsp_item_type   rsp_item_ff, rsp_item_in;

   mlr_pkg::line_state_type setup;
   mlr_pkg::line_state_type stepped;
   logic                    step_last;
   logic                    fire;
   logic                    emit;

   mlr_line_setup u_setup (
      .pen_x   (pen_x_ff),
      .pen_y   (pen_y_ff),
      .point_x (in_item_ff.point_x),
      .point_y (in_item_ff.point_y),
      .setup   (setup)
   );

   mlr_pixel_step u_step (
      .cur  (line_ff),
      .nxt  (stepped),
      .last (step_last)
   );

   // Handshake: the held item executes when the result register can take a pixel
   assign fire      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign emit      = fire && (in_item_ff.func == mlr_pkg::FUNC_STEP) && busy_ff;
   assign req_ready = !in_valid_ff || fire;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // Command execution
   always_comb begin
      in_valid_in  = req_ready ? req_valid : in_valid_ff;
      pen_x_in     = pen_x_ff;
      pen_y_in     = pen_y_ff;
      busy_in      = busy_ff;
      line_in      = line_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_item_in  = rsp_item_ff;
      if (fire) begin
         case (in_item_ff.func)
            mlr_pkg::FUNC_MOVE: begin
               busy_in  = 1'b0;
               pen_x_in = in_item_ff.point_x;
               pen_y_in = in_item_ff.point_y;
            end
            mlr_pkg::FUNC_LINE: begin
               busy_in  = 1'b1;
               line_in  = setup;
               pen_x_in = in_item_ff.point_x;
               pen_y_in = in_item_ff.point_y;
            end
            mlr_pkg::FUNC_STEP: begin
               if (busy_ff) begin
                  rsp_valid_in        = 1'b1;
                  rsp_item_in.pixel_x = line_ff.walk_x;
                  rsp_item_in.pixel_y = line_ff.walk_y;
                  rsp_item_in.last    = step_last;
                  line_in             = stepped;
                  busy_in             = !step_last;
               end
            end
            default: begin
               busy_in = busy_ff;
            end
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pen_x_ff     <= '0;
         pen_y_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         pen_x_ff     <= pen_x_in;
         pen_y_ff     <= pen_y_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_ready) begin
         in_item_ff <= req_item;
      end
      line_ff     <= line_in;
      rsp_item_ff <= rsp_item_in;
   end

`ifndef SYNTHESIS
   // A pixel appears only after a step item ran on an active line
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(emit))
      else $error("result without an executed step item");

   // The final pixel ends the line
   assert property (@(posedge clock) disable iff (reset)
      (emit && step_last) |=> !busy_ff)
      else $error("line still active after its final pixel");

   // A line command always leaves a line active
   assert property (@(posedge clock) disable iff (reset)
      (fire && (in_item_ff.func == mlr_pkg::FUNC_LINE)) |=> busy_ff)
      else $error("line command did not start a line");

   // Input stalls only behind a held item and a stalled pixel
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_valid_ff && rsp_valid_ff && !rsp_ready))
      else $error("input stalled without back-pressure");
`endif

endmodule

// ===== rtl/core/mlr_line_setup.sv =====
`timescale 1ns / 1ps
// Line setup: classifies the line from the pen to the new point and builds
// the starting walk state. Depends on mlr_pkg.
module mlr_line_setup (
   input  mlr_pkg::coord_type      pen_x,
   input  mlr_pkg::coord_type      pen_y,
   input  mlr_pkg::coord_type      point_x,
   input  mlr_pkg::coord_type      point_y,
   output mlr_pkg::line_state_type setup
);

   mlr_pkg::ext_coord_type dx;
   mlr_pkg::ext_coord_type dy;
   mlr_pkg::ext_coord_type adx_full;
   mlr_pkg::ext_coord_type ady_full;
   mlr_pkg::delta_type     adx;
   mlr_pkg::delta_type     ady;
   mlr_pkg::decision_type  dec_adx;
   mlr_pkg::decision_type  dec_ady;
   logic                   dx_neg, dx_zero, dx_pos;
   logic                   dy_neg, dy_zero, dy_pos;
   logic                   same_dir;
   logic                   shallow;
   mlr_pkg::coord_type     sx, sy, ex, ey;

   // Deltas and magnitudes
   always_comb begin
      dx       = mlr_pkg::sext(point_x) - mlr_pkg::sext(pen_x);
      dy       = mlr_pkg::sext(point_y) - mlr_pkg::sext(pen_y);
      dx_neg   = dx[mlr_pkg::EXT_BITS-1];
      dy_neg   = dy[mlr_pkg::EXT_BITS-1];
      dx_zero  = (dx == '0);
      dy_zero  = (dy == '0);
      dx_pos   = !dx_neg && !dx_zero;
      dy_pos   = !dy_neg && !dy_zero;
      adx_full = dx_neg ? -dx : dx;
      ady_full = dy_neg ? -dy : dy;
      adx      = adx_full[mlr_pkg::COORD_BITS-1:0];
      ady      = ady_full[mlr_pkg::COORD_BITS-1:0];
      dec_adx  = mlr_pkg::widen(adx);
      dec_ady  = mlr_pkg::widen(ady);
      same_dir = (dx_pos == dy_pos);
      shallow  = (ady <= adx);
   end

   // Walk starts at the lower-x end unless the case says otherwise
   always_comb begin
      if (dx_neg) begin
         sx = point_x;
         sy = point_y;
         ex = pen_x;
         ey = pen_y;
      end else begin
         sx = pen_x;
         sy = pen_y;
         ex = point_x;
         ey = point_y;
      end

      setup.delta_x = adx;
      setup.delta_y = ady;
      setup.walk_x  = sx;
      setup.walk_y  = sy;

      if (dx_zero) begin
         setup.line_case  = mlr_pkg::CASE_VERT;
         setup.walk_x     = pen_x;
         setup.walk_y     = dy_pos ? pen_y : point_y;
         setup.stop_coord = dy_pos ? point_y : pen_y;
         setup.decision   = '0;
      end else if (dy_zero || (same_dir && shallow)) begin
         setup.line_case  = mlr_pkg::CASE_SH_UP;
         setup.stop_coord = ex;
         setup.decision   = dec_adx - (dec_ady <<< 1);
      end else if (same_dir) begin
         setup.line_case  = mlr_pkg::CASE_ST_UP;
         setup.stop_coord = ey;
         setup.decision   = (dec_adx <<< 1) - dec_ady;
      end else if (shallow) begin
         setup.line_case  = mlr_pkg::CASE_SH_DN;
         setup.stop_coord = ex;
         setup.decision   = (dec_ady <<< 1) - dec_adx;
      end else begin
         setup.line_case  = mlr_pkg::CASE_ST_DN;
         setup.stop_coord = ey;
         setup.decision   = dec_ady - (dec_adx <<< 1);
      end
   end

endmodule

// ===== rtl/core/mlr_pixel_step.sv =====
`timescale 1ns / 1ps
// Pixel step: from the current walk state, flags the final pixel and
// advances position and decision by one pixel. Depends on mlr_pkg.
module mlr_pixel_step (
   input  mlr_pkg::line_state_type cur,
   output mlr_pkg::line_state_type nxt,
   output logic                    last
);

   mlr_pkg::ext_coord_type wx, wy, stop;
   mlr_pkg::ext_coord_type wx_inc, wy_inc, wy_dec;
   mlr_pkg::decision_type  two_dx, two_dy, two_diff;
   logic                   d_neg, d_pos;

   // Shared sums
   always_comb begin
      wx       = mlr_pkg::sext(cur.walk_x);
      wy       = mlr_pkg::sext(cur.walk_y);
      stop     = mlr_pkg::sext(cur.stop_coord);
      wx_inc   = wx + mlr_pkg::EXT_BITS'(1);
      wy_inc   = wy + mlr_pkg::EXT_BITS'(1);
      wy_dec   = wy - mlr_pkg::EXT_BITS'(1);
      two_dx   = mlr_pkg::widen(cur.delta_x) <<< 1;
      two_dy   = mlr_pkg::widen(cur.delta_y) <<< 1;
      two_diff = two_dx - two_dy;
      d_neg    = cur.decision[mlr_pkg::DEC_BITS-1];
      d_pos    = !d_neg && (cur.decision != '0);
   end

   // Per-case advance
   always_comb begin
      nxt  = cur;
      last = 1'b1;
      case (cur.line_case)
         mlr_pkg::CASE_VERT: begin
            last       = (wy >= stop);
            nxt.walk_y = wy_inc[mlr_pkg::COORD_BITS-1:0];
         end
         mlr_pkg::CASE_SH_UP: begin
            last       = (wx_inc >= stop);
            nxt.walk_x = wx_inc[mlr_pkg::COORD_BITS-1:0];
            if (d_neg) begin
               nxt.walk_y   = wy_inc[mlr_pkg::COORD_BITS-1:0];
               nxt.decision = cur.decision + two_diff;
            end else begin
               nxt.decision = cur.decision - two_dy;
            end
         end
         mlr_pkg::CASE_SH_DN: begin
            last       = (wx_inc >= stop);
            nxt.walk_x = wx_inc[mlr_pkg::COORD_BITS-1:0];
            if (d_pos) begin
               nxt.walk_y   = wy_dec[mlr_pkg::COORD_BITS-1:0];
               nxt.decision = cur.decision - two_diff;
            end else begin
               nxt.decision = cur.decision + two_dy;
            end
         end
         mlr_pkg::CASE_ST_UP: begin
            last       = (wy_inc >= stop);
            nxt.walk_y = wy_inc[mlr_pkg::COORD_BITS-1:0];
            if (!d_neg) begin
               nxt.walk_x   = wx_inc[mlr_pkg::COORD_BITS-1:0];
               nxt.decision = cur.decision + two_diff;
            end else begin
               nxt.decision = cur.decision + two_dx;
            end
         end
         mlr_pkg::CASE_ST_DN: begin
            last       = (wy_dec <= stop);
            nxt.walk_y = wy_dec[mlr_pkg::COORD_BITS-1:0];
            if (d_neg) begin
               nxt.walk_x   = wx_inc[mlr_pkg::COORD_BITS-1:0];
               nxt.decision = cur.decision - two_diff;
            end else begin
               nxt.decision = cur.decision - two_dx;
            end
         end
         default: begin
            last = 1'b1;
         end
      endcase
   end

endmodule

// ===== tb/midpoint_line_rasterizer_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for midpoint_line_rasterizer: directed corner lines, then random
// pen/line/step sequences under varying backpressure. Depends on mlr_pkg and the RTL.
module midpoint_line_rasterizer_tb;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   mlr_pkg::req_item_type req_item  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   mlr_pkg::rsp_item_type rsp_item;

   midpoint_line_rasterizer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   mlr_pkg::req_item_type command_q[$];
   mlr_pkg::rsp_item_type pixel_expect[$];
   int                    errors      = 0;
   int                    items_taken = 0;

   // Shadow of the rasterizer state
   int                     pen_x, pen_y, walk_x, walk_y, stop_at, mag_x, mag_y, midpoint_err;
   mlr_pkg::line_case_type line_kind;
   bit                     drawing;

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      errors++;
   endtask

   // Latch a line from the pen to (x1, y1) and classify it
   task automatic latch_line(input int x1, input int y1);
      int dx, dy, adx, ady, sx, sy, ex, ey;
      bit same;
      dx   = x1 - pen_x;
      dy   = y1 - pen_y;
      adx  = dx < 0 ? -dx : dx;
      ady  = dy < 0 ? -dy : dy;
      same = (dx > 0) == (dy > 0);
      if (dx < 0) begin
         sx = x1; sy = y1; ex = pen_x; ey = pen_y;
      end else begin
         sx = pen_x; sy = pen_y; ex = x1; ey = y1;
      end
      mag_x = adx;
      mag_y = ady;
      if (dx == 0) begin
         line_kind    = mlr_pkg::CASE_VERT;
         sx           = pen_x;
         sy           = pen_y < y1 ? pen_y : y1;
         stop_at      = pen_y < y1 ? y1 : pen_y;
         midpoint_err = 0;
      end else if (dy == 0 || (same && ady <= adx)) begin
         line_kind    = mlr_pkg::CASE_SH_UP;
         stop_at      = ex;
         midpoint_err = adx - 2 * ady;
      end else if (same) begin
         line_kind    = mlr_pkg::CASE_ST_UP;
         stop_at      = ey;
         midpoint_err = 2 * adx - ady;
      end else if (ady <= adx) begin
         line_kind    = mlr_pkg::CASE_SH_DN;
         stop_at      = ex;
         midpoint_err = 2 * ady - adx;
      end else begin
         line_kind    = mlr_pkg::CASE_ST_DN;
         stop_at      = ey;
         midpoint_err = ady - 2 * adx;
      end
      walk_x  = sx;
      walk_y  = sy;
      drawing = 1'b1;
      pen_x   = x1;
      pen_y   = y1;
   endtask

   // Advance the shadow by one accepted item; a step on an active line yields a pixel
   task automatic rasterize(input mlr_pkg::req_item_type it);
      mlr_pkg::rsp_item_type pix;
      bit fin;
      case (it.func)
         mlr_pkg::FUNC_MOVE: begin
            drawing = 1'b0;
            pen_x   = int'(it.point_x);
            pen_y   = int'(it.point_y);
         end
         mlr_pkg::FUNC_LINE: latch_line(int'(it.point_x), int'(it.point_y));
         mlr_pkg::FUNC_STEP: if (drawing) begin
            pix.pixel_x = mlr_pkg::coord_type'(walk_x);
            pix.pixel_y = mlr_pkg::coord_type'(walk_y);
            case (line_kind)
               mlr_pkg::CASE_VERT: begin
                  fin    = walk_y >= stop_at;
                  walk_y = walk_y + 1;
               end
               mlr_pkg::CASE_SH_UP: begin
                  fin = walk_x + 1 >= stop_at;
                  if (midpoint_err < 0) begin
                     walk_y       = walk_y + 1;
                     midpoint_err = midpoint_err + 2 * mag_x - 2 * mag_y;
                  end else begin
                     midpoint_err = midpoint_err - 2 * mag_y;
                  end
                  walk_x = walk_x + 1;
               end
               mlr_pkg::CASE_SH_DN: begin
                  fin = walk_x + 1 >= stop_at;
                  if (midpoint_err > 0) begin
                     walk_y       = walk_y - 1;
                     midpoint_err = midpoint_err - (2 * mag_x - 2 * mag_y);
                  end else begin
                     midpoint_err = midpoint_err + 2 * mag_y;
                  end
                  walk_x = walk_x + 1;
               end
               mlr_pkg::CASE_ST_UP: begin
                  fin = walk_y + 1 >= stop_at;
                  if (midpoint_err >= 0) begin
                     walk_x       = walk_x + 1;
                     midpoint_err = midpoint_err + 2 * mag_x - 2 * mag_y;
                  end else begin
                     midpoint_err = midpoint_err + 2 * mag_x;
                  end
                  walk_y = walk_y + 1;
               end
               mlr_pkg::CASE_ST_DN: begin
                  fin = walk_y - 1 <= stop_at;
                  if (midpoint_err < 0) begin
                     walk_x       = walk_x + 1;
                     midpoint_err = midpoint_err - (2 * mag_x - 2 * mag_y);
                  end else begin
                     midpoint_err = midpoint_err - 2 * mag_x;
                  end
                  walk_y = walk_y - 1;
               end
               default: fin = 1'b1;
            endcase
            pix.last = fin;
            if (fin) drawing = 1'b0;
            pixel_expect.push_back(pix);
         end
         default: ;
      endcase
   endtask

   task automatic check_pixel(input mlr_pkg::rsp_item_type got);
      mlr_pkg::rsp_item_type want;
      if (pixel_expect.size() == 0) begin
         report_mismatch($sformatf("pixel (%0d,%0d) with none expected",
                                   got.pixel_x, got.pixel_y));
      end else begin
         want = pixel_expect.pop_front();
         if (got.pixel_x !== want.pixel_x)
            report_mismatch($sformatf("pixel_x got %0d want %0d", got.pixel_x, want.pixel_x));
         if (got.pixel_y !== want.pixel_y)
            report_mismatch($sformatf("pixel_y got %0d want %0d", got.pixel_y, want.pixel_y));
         if (got.last !== want.last)
            report_mismatch($sformatf("last got %0b want %0b at (%0d,%0d)",
                                      got.last, want.last, want.pixel_x, want.pixel_y));
      end
   endtask

   // Monitor: check the result first, then predict from the item taken on the same edge
   always @(posedge clock) begin
      if (reset) begin
         pen_x = 0; pen_y = 0; walk_x = 0; walk_y = 0; stop_at = 0;
         mag_x = 0; mag_y = 0; midpoint_err = 0;
         line_kind = mlr_pkg::CASE_VERT;
         drawing   = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) check_pixel(rsp_item);
         if (req_valid && req_ready) begin
            rasterize(req_item);
            items_taken++;
         end
      end
   end

   // Idle pattern rotates every 200 accepted items: none, sender, receiver, both
   function automatic bit idle_roll(input bit sender_side);
      int phase;
      phase = (items_taken / 200) % 4;
      case (phase)
         1:       return sender_side ? ($urandom_range(0, 99) < 66) : 1'b0;
         2:       return sender_side ? 1'b0 : ($urandom_range(0, 99) < 66);
         3:       return $urandom_range(0, 99) < 28;
         default: return 1'b0;
      endcase
   endfunction

   // Request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (command_q.size() != 0 && !idle_roll(1'b1)) begin
            req_valid <= 1'b1;
            req_item  <= command_q.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result backpressure
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else       rsp_ready <= !idle_roll(1'b0);
   end

   // Stimulus generator keeps its own pen to build well-formed lines
   int gen_pen_x = 0, gen_pen_y = 0;

   task automatic push_cmd(input mlr_pkg::func_type f, input int x, input int y);
      mlr_pkg::req_item_type it;
      it.func    = f;
      it.point_x = mlr_pkg::coord_type'(x);
      it.point_y = mlr_pkg::coord_type'(y);
      command_q.push_back(it);
      if (f == mlr_pkg::FUNC_MOVE || f == mlr_pkg::FUNC_LINE) begin
         gen_pen_x = int'(it.point_x);
         gen_pen_y = int'(it.point_y);
      end
   endtask

   function automatic int rand_coord();
      return int'(mlr_pkg::coord_type'($urandom_range(0, 4095)));
   endfunction

   // Signed offset that keeps pen + offset inside the coordinate range
   function automatic int fit_offset(input int base, input int ofs);
      if (base + ofs > 2047 || base + ofs < -2048) return -ofs;
      return ofs;
   endfunction

   task automatic build_stimulus();
      int counted, pick, span, dx, dy, adx, ady, npix, nstep;
      // Directed corners: idle step, ignored code, zero-length line, extreme lines
      // abandoned mid-walk, and a short steep falling line run to its end
      push_cmd(mlr_pkg::FUNC_STEP, 0, 0);
      push_cmd(mlr_pkg::func_type'(2'd3), -2048, -2048);
      push_cmd(mlr_pkg::FUNC_LINE, 0, 0);
      push_cmd(mlr_pkg::FUNC_STEP, 0, 0);
      push_cmd(mlr_pkg::FUNC_STEP, 0, 0);
      push_cmd(mlr_pkg::FUNC_MOVE, -2048, -2048);
      push_cmd(mlr_pkg::FUNC_LINE, 2047, 2047);
      push_cmd(mlr_pkg::FUNC_STEP, 0, 0);
      push_cmd(mlr_pkg::FUNC_STEP, 0, 0);
      push_cmd(mlr_pkg::FUNC_MOVE, 2047, -2048);
      push_cmd(mlr_pkg::FUNC_LINE, -2048, 2047);
      push_cmd(mlr_pkg::FUNC_STEP, 0, 0);
      push_cmd(mlr_pkg::FUNC_LINE, -2048, -2048);
      push_cmd(mlr_pkg::FUNC_STEP, 0, 0);
      push_cmd(mlr_pkg::FUNC_STEP, 0, 0);
      push_cmd(mlr_pkg::FUNC_LINE, -2047, 2047);
      push_cmd(mlr_pkg::FUNC_STEP, 0, 0);
      push_cmd(mlr_pkg::FUNC_MOVE, 0, 0);
      push_cmd(mlr_pkg::FUNC_LINE, 1, -3);
      repeat (3) push_cmd(mlr_pkg::FUNC_STEP, 0, 0);
      push_cmd(mlr_pkg::func_type'(2'd3), 2047, 2047);

      // Random part: mostly complete lines, some abandoned, overrun, or noise
      counted = 0;
      while (counted < 2000) begin
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            push_cmd(mlr_pkg::func_type'($urandom_range(0, 3)), rand_coord(), rand_coord());
            counted++;
         end else begin
            if ($urandom_range(0, 99) < 65) begin
               push_cmd(mlr_pkg::FUNC_MOVE, rand_coord(), rand_coord());
               counted++;
            end
            span = ($urandom_range(0, 99) < 10) ? 150 : 12;
            dx   = int'($urandom_range(0, 2 * span)) - span;
            dy   = int'($urandom_range(0, 2 * span)) - span;
            pick = $urandom_range(0, 99);
            if (pick < 15)      dx = 0;
            else if (pick < 25) dy = 0;
            else if (pick < 35) dy = ($urandom_range(0, 1) ? dx : -dx);
            dx  = fit_offset(gen_pen_x, dx);
            dy  = fit_offset(gen_pen_y, dy);
            adx = dx < 0 ? -dx : dx;
            ady = dy < 0 ? -dy : dy;
            if (dx == 0)        npix = ady + 1;
            else if (ady <= adx) npix = adx;
            else                 npix = ady;
            push_cmd(mlr_pkg::FUNC_LINE, gen_pen_x + dx, gen_pen_y + dy);
            counted++;
            pick = $urandom_range(0, 99);
            if (pick < 75)      nstep = npix;
            else if (pick < 85) nstep = npix + int'($urandom_range(1, 3));
            else                nstep = int'($urandom_range(0, npix - 1));
            repeat (nstep) push_cmd(mlr_pkg::FUNC_STEP, 0, 0);
            counted += (nstep < npix) ? nstep : npix;
         end
      end
   endtask

   // Reset, stimulus, drain and verdict
   initial begin
      build_stimulus();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      while (command_q.size() != 0 || req_valid) @(posedge clock);
      while (pixel_expect.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (errors == 0 && pixel_expect.size() == 0) begin
         $display("midpoint_line_rasterizer_tb: done, clean");
      end else begin
         $display("midpoint_line_rasterizer_tb: done, errors");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #4_000_000;
      $display("midpoint_line_rasterizer_tb: done, errors");
      $finish;
   end

endmodule
